/* src/int_to_ascii_formatter_unit_assert.svh */
// ----------------------------------------------------------------------------
// int_to_ascii_formatter_unit assertion macros
// concurrent checks on i_clk, held off while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef INT_TO_ASCII_FORMATTER_UNIT_ASSERT_SVH
`define INT_TO_ASCII_FORMATTER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define ITOAF_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("itoaf assertion failed");

// antecedent implies consequent in the next cycle
`define ITOAF_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("itoaf assertion failed");

`else

`define ITOAF_ASSERT_IMP(label, ante, cons)
`define ITOAF_ASSERT_NXT(label, ante, cons)

`endif

`endif

/* src/itoaf_pkg.sv */
// ----------------------------------------------------------------------------
// itoaf_pkg
// widths, opcodes, character codes and place-value table of the formatter
// ----------------------------------------------------------------------------
package itoaf_pkg;

    localparam int VALUE_W  = 32;
    localparam int OPCODE_W = 2;
    localparam int CHAR_W   = 7;
    localparam int POS_W    = 4;
    localparam int DIGIT_W  = 4;

    typedef logic [VALUE_W-1:0]  t_value;
    typedef logic [OPCODE_W-1:0] t_opcode;
    typedef logic [CHAR_W-1:0]   t_char;
    typedef logic [POS_W-1:0]    t_pos;
    typedef logic [DIGIT_W-1:0]  t_digit;

    // format opcodes
    localparam t_opcode OP_SDEC = 2'd0;
    localparam t_opcode OP_UDEC = 2'd1;
    localparam t_opcode OP_HEX  = 2'd2;
    localparam t_opcode OP_RSVD = 2'd3;

    // ascii codes
    localparam t_char CH_ZERO  = 7'h30;
    localparam t_char CH_UPPER = 7'h41;
    localparam t_char CH_X     = 7'h78;
    localparam t_char CH_SPACE = 7'h20;
    localparam t_char CH_MINUS = 7'h2D;

    // most significant place of each radix
    localparam t_pos TOP_POS_DEC = 4'd9;
    localparam t_pos TOP_POS_HEX = 4'd7;

    // weight of a digit place: 10^pos or 16^pos
    function automatic t_value place_value(input logic hex, input t_pos pos);
        t_value v;
        if (hex) begin
            v = t_value'(32'd1) << {pos[2:0], 2'b00};
        end else begin
            unique case (pos)
                4'd0:    v = 32'd1;
                4'd1:    v = 32'd10;
                4'd2:    v = 32'd100;
                4'd3:    v = 32'd1000;
                4'd4:    v = 32'd10000;
                4'd5:    v = 32'd100000;
                4'd6:    v = 32'd1000000;
                4'd7:    v = 32'd10000000;
                4'd8:    v = 32'd100000000;
                4'd9:    v = 32'd1000000000;
                default: v = 32'd0;
            endcase
        end
        return v;
    endfunction

    // digit to uppercase ascii
    function automatic t_char digit_char(input t_digit d);
        t_char c;
        if (d < 4'd10) begin
            c = CH_ZERO + t_char'(d);
        end else begin
            c = CH_UPPER + t_char'(d) - t_char'(7'd10);
        end
        return c;
    endfunction

endpackage

/* src/itoaf_if.sv */
// ----------------------------------------------------------------------------
// itoaf channel interfaces
// valid/ready channels for requests in and characters out
// ----------------------------------------------------------------------------
interface itoaf_in_if;
    logic                                  valid;
    logic                                  ready;
    logic [itoaf_pkg::VALUE_W-1:0]         value;
    logic [itoaf_pkg::OPCODE_W-1:0]        opcode;

    modport source (output valid, output value, output opcode, input ready);
    modport sink   (input valid, input value, input opcode, output ready);
endinterface

interface itoaf_out_if;
    logic                                  valid;
    logic                                  ready;
    logic [itoaf_pkg::CHAR_W-1:0]          ascii_char;
    logic                                  last;

    modport source (output valid, output ascii_char, output last, input ready);
    modport sink   (input valid, input ascii_char, input last, output ready);
endinterface

/* src/int_to_ascii_formatter_unit.sv */
// ----------------------------------------------------------------------------
// int_to_ascii_formatter_unit
// prints a 32-bit word as signed decimal, unsigned decimal or 0x hex text
// ----------------------------------------------------------------------------
// usage
//   i_in  : request channel, value plus opcode (0 signed dec, 1 unsigned dec,
//           2 hex with 0x prefix, 3 dropped without any output)
//   o_out : one ascii character per transfer, most significant digit first,
//           no leading zeros, closed by a space flagged with last
// timing
//   one request at a time; ready is high only while the sequencer is idle
//   each digit place takes four compare-subtract steps on the shared 35-bit
//   comparator against 8p, 4p, 2p, p, then an emit step
//   decimal: 10 places; hex: 8 places
//   when a prefix exists, the first character leaves from the prefix step
// stalls
//   the single output register holds its character while o_out.ready is low;
//   prefix, emit and space steps wait for it, digit steps carry on
// reset
//   sequencer returns to idle and the output register empties
// ----------------------------------------------------------------------------
`include "int_to_ascii_formatter_unit_assert.svh"

module int_to_ascii_formatter_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    itoaf_in_if.sink    i_in,
    itoaf_out_if.source o_out
);
    import itoaf_pkg::*;

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PREFIX = 3'd1;
    localparam logic [2:0] S_DIGIT  = 3'd2;
    localparam logic [2:0] S_EMIT   = 3'd3;
    localparam logic [2:0] S_SPACE  = 3'd4;

    // control
    logic [2:0] r_state, n_state;
    // working value, shrinks as each place is taken out
    t_value     r_rem, n_rem;
    t_pos       r_pos, n_pos;
    logic [1:0] r_bit, n_bit;
    t_digit     r_digit, n_digit;
    logic       r_hex, n_hex;
    logic       r_started, n_started;
    // prefix characters still to send ('-' or "0x")
    logic [1:0] r_pfx, n_pfx;

    // output register
    logic       r_out_valid, n_out_valid;
    t_char      r_out_char, n_out_char;
    logic       r_out_last, n_out_last;

    // shared compare-subtract unit
    t_value      w_place;
    logic [34:0] w_shifted;
    logic        w_ge;

    logic        w_accept;
    logic        w_out_free;
    logic        w_emit;
    t_char       w_emit_char;
    logic        w_emit_last;

    assign w_accept   = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.ascii_char = r_out_char;
    assign o_out.last       = r_out_last;

    // weight of this place shifted by 3, 2, 1, 0 for the greedy digit search
    assign w_place   = place_value(r_hex, r_pos);
    assign w_shifted = {3'b000, w_place} << (2'd3 - r_bit);
    assign w_ge      = {3'b000, r_rem} >= w_shifted;

    always_comb begin
        n_state     = r_state;
        n_rem       = r_rem;
        n_pos       = r_pos;
        n_bit       = r_bit;
        n_digit     = r_digit;
        n_hex       = r_hex;
        n_started   = r_started;
        n_pfx       = r_pfx;
        w_emit      = 1'b0;
        w_emit_char = CH_SPACE;
        w_emit_last = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_hex     = (i_in.opcode == OP_HEX);
                    n_pos     = (i_in.opcode == OP_HEX) ? TOP_POS_HEX : TOP_POS_DEC;
                    n_bit     = 2'd0;
                    n_started = 1'b0;
                    n_rem     = i_in.value;
                    n_pfx     = 2'd0;
                    n_state   = S_DIGIT;
                    priority if (i_in.opcode == OP_RSVD) begin
                        // nothing printed for the unused opcode
                        n_state = S_IDLE;
                    end else if (i_in.opcode == OP_HEX) begin
                        n_pfx   = 2'd2;
                        n_state = S_PREFIX;
                    end else if (i_in.opcode == OP_SDEC && i_in.value[VALUE_W-1]) begin
                        // magnitude of a negative word, the minimum maps onto itself
                        n_rem   = t_value'(0) - i_in.value;
                        n_pfx   = 2'd1;
                        n_state = S_PREFIX;
                    end else begin
                        n_state = S_DIGIT;
                    end
                end
            end
            S_PREFIX: begin
                if (w_out_free) begin
                    w_emit = 1'b1;
                    if (r_hex) begin
                        w_emit_char = (r_pfx == 2'd2) ? CH_ZERO : CH_X;
                    end else begin
                        w_emit_char = CH_MINUS;
                    end
                    n_pfx = r_pfx - 2'd1;
                    if (r_pfx == 2'd1) begin
                        n_state = S_DIGIT;
                    end
                end
            end
            S_DIGIT: begin
                // one bit of the digit per cycle, msb first
                n_digit = {((r_bit == 2'd0) ? 3'b000 : r_digit[2:0]), w_ge};
                if (w_ge) begin
                    n_rem = r_rem - w_shifted[VALUE_W-1:0];
                end
                n_bit = r_bit + 2'd1;
                if (r_bit == 2'd3) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                // leading zeros are skipped, the units place always prints
                if (r_digit != '0 || r_started || r_pos == '0) begin
                    if (w_out_free) begin
                        w_emit      = 1'b1;
                        w_emit_char = digit_char(r_digit);
                        n_started   = 1'b1;
                        n_state     = (r_pos == '0) ? S_SPACE : S_DIGIT;
                        n_pos       = r_pos - 4'd1;
                        n_bit       = 2'd0;
                    end
                end else begin
                    n_state = S_DIGIT;
                    n_pos   = r_pos - 4'd1;
                    n_bit   = 2'd0;
                end
            end
            S_SPACE: begin
                if (w_out_free) begin
                    w_emit      = 1'b1;
                    w_emit_char = CH_SPACE;
                    w_emit_last = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output register loads on an emit, empties when taken
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        if (w_emit) begin
            n_out_valid = 1'b1;
            n_out_char  = w_emit_char;
            n_out_last  = w_emit_last;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem      <= n_rem;
        r_pos      <= n_pos;
        r_bit      <= n_bit;
        r_digit    <= n_digit;
        r_hex      <= n_hex;
        r_started  <= n_started;
        r_pfx      <= n_pfx;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    // checks
    `ITOAF_ASSERT_IMP(a_last_is_space, r_out_valid && r_out_last, r_out_char == CH_SPACE)
    `ITOAF_ASSERT_NXT(a_rsvd_dropped, w_accept && i_in.opcode == OP_RSVD, r_state == S_IDLE)
    `ITOAF_ASSERT_IMP(a_rem_in_range, r_state == S_DIGIT && r_bit == 2'd0, (r_rem >> 4) < w_place)
    `ITOAF_ASSERT_IMP(a_dec_digit, r_state == S_EMIT && !r_hex, r_digit <= 4'd9)
    `ITOAF_ASSERT_NXT(a_emit_valid, w_emit, r_out_valid)

endmodule

/* verif/int_to_ascii_formatter_unit_tb.sv */
// ----------------------------------------------------------------------------
// int_to_ascii_formatter_unit_tb
// self-checking bench for the word-to-text formatter: a short table of
// directed requests, then random requests, every character checked in order
// against given or predicted text while both channels idle and stall at random
// ----------------------------------------------------------------------------
module int_to_ascii_formatter_unit_tb;

    import itoaf_pkg::*;

    localparam int RANDOM_ITEMS  = 190;
    localparam int DRAIN_EVERY   = 64;
    localparam int TAIL_CYCLES   = 80;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int REPORT_LIMIT  = 10;
    localparam string HEX_DIGITS = "0123456789ABCDEF";

    // one request and, for table rows, the text it must print
    typedef struct {
        t_value  value;
        t_opcode opcode;
        bit      typed;
        string   text;
    } t_request;

    // one expected character
    typedef struct {
        t_char ch;
        logic  last;
    } t_glyph;

    logic clk   = 1'b0;
    logic rst_n;

    itoaf_in_if  req_if ();
    itoaf_out_if chr_if ();

    int_to_ascii_formatter_unit dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (req_if),
        .o_out   (chr_if)
    );

    t_request pending_q[$];
    t_glyph   expected_chars_q[$];
    int       mismatch_count = 0;
    int       cycle_count    = 0;
    int       src_calm_left  = 0;

    // directed table: text given where it is plain, else predicted
    t_request directed_rows[22] = '{
        '{32'h0000_0000, OP_SDEC, 1'b1, "0 "},
        '{32'h0000_0000, OP_UDEC, 1'b1, "0 "},
        '{32'h0000_0000, OP_HEX,  1'b1, "0x0 "},
        '{32'h7FFF_FFFF, OP_SDEC, 1'b1, "2147483647 "},
        '{32'h8000_0000, OP_SDEC, 1'b1, "-2147483648 "},
        '{32'hFFFF_FFFF, OP_SDEC, 1'b1, "-1 "},
        '{32'hFFFF_FFFF, OP_UDEC, 1'b1, "4294967295 "},
        '{32'hFFFF_FFFF, OP_HEX,  1'b1, "0xFFFFFFFF "},
        '{32'h8000_0000, OP_UDEC, 1'b1, "2147483648 "},
        '{32'h8000_0000, OP_HEX,  1'b1, "0x80000000 "},
        '{32'h0000_0001, OP_SDEC, 1'b1, "1 "},
        '{32'h0000_000A, OP_UDEC, 1'b1, "10 "},
        '{32'hFFFF_FFF6, OP_SDEC, 1'b1, "-10 "},
        '{32'h0000_000F, OP_HEX,  1'b1, "0xF "},
        '{32'h0000_0010, OP_HEX,  1'b1, "0x10 "},
        '{32'hABCD_EF01, OP_HEX,  1'b1, "0xABCDEF01 "},
        '{32'd1000000000, OP_UDEC, 1'b1, "1000000000 "},
        '{32'h1234_5678, OP_RSVD, 1'b1, ""},
        '{32'hFFFF_FFFF, OP_RSVD, 1'b1, ""},
        '{32'd999999999, OP_SDEC, 1'b0, ""},
        '{32'h8000_0001, OP_SDEC, 1'b0, ""},
        '{32'h0000_FFFF, OP_UDEC, 1'b0, ""}
    };

    // clock, period 4
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void log_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("%s", msg);
        end
    endfunction

    function automatic void push_glyph(input t_char ch, input logic last);
        t_glyph g;
        g.ch   = ch;
        g.last = last;
        expected_chars_q.push_back(g);
    endfunction

    // text of a word: optional sign or 0x, digits msd first, closing space
    function automatic void predict_text(input t_value value, input t_opcode opcode);
        t_char  digits[$];
        t_value mag;
        t_value radix;
        if (opcode == OP_RSVD) begin
            return;
        end
        mag   = value;
        radix = (opcode == OP_HEX) ? 32'd16 : 32'd10;
        if (opcode == OP_SDEC && value[VALUE_W-1]) begin
            push_glyph(CH_MINUS, 1'b0);
            mag = 32'd0 - value;
        end
        if (opcode == OP_HEX) begin
            push_glyph(CH_ZERO, 1'b0);
            push_glyph(CH_X, 1'b0);
        end
        // zero still gives one digit
        do begin
            digits.push_front(t_char'(HEX_DIGITS[int'(mag % radix)]));
            mag = mag / radix;
        end while (mag != 0);
        foreach (digits[i]) begin
            push_glyph(digits[i], 1'b0);
        end
        push_glyph(CH_SPACE, 1'b1);
    endfunction

    // watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // output checks first, then expectations of a request taken at this edge;
    // characters of a new request cannot appear at its own acceptance edge
    always @(posedge clk) begin
        t_glyph   want;
        t_request req;
        if (rst_n === 1'b1) begin
            if (chr_if.valid === 1'b1 && chr_if.ready === 1'b1) begin
                if (expected_chars_q.size() == 0) begin
                    log_mismatch($sformatf("unexpected char %02h last %b",
                                           chr_if.ascii_char, chr_if.last));
                end else begin
                    want = expected_chars_q.pop_front();
                    if (chr_if.ascii_char !== want.ch) begin
                        log_mismatch($sformatf("char: expected %02h got %02h",
                                               want.ch, chr_if.ascii_char));
                    end
                    if (chr_if.last !== want.last) begin
                        log_mismatch($sformatf("last on %02h: expected %b got %b",
                                               want.ch, want.last, chr_if.last));
                    end
                end
            end
            if (req_if.valid === 1'b1 && req_if.ready === 1'b1
                && pending_q.size() != 0) begin
                req = pending_q.pop_front();
                if (req.typed) begin
                    for (int i = 0; i < req.text.len(); i++) begin
                        push_glyph(t_char'(req.text[i]), i == req.text.len() - 1);
                    end
                end else begin
                    predict_text(req.value, req.opcode);
                end
            end
        end
    end

    // character sink: short stalls, a few long ones, and calm stretches
    initial begin
        int stall_left;
        int calm_left;
        int r;
        stall_left    = 0;
        calm_left     = 0;
        chr_if.ready  = 1'b0;
        forever begin
            @(posedge clk);
            if (stall_left > 0) begin
                stall_left--;
                chr_if.ready <= 1'b0;
            end else if (calm_left > 0) begin
                calm_left--;
                chr_if.ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 3) begin
                    calm_left = $urandom_range(50, 300);
                    chr_if.ready <= 1'b1;
                end else if (r < 6) begin
                    stall_left = $urandom_range(10, 40);
                    chr_if.ready <= 1'b0;
                end else if (r < 35) begin
                    stall_left = $urandom_range(0, 3);
                    chr_if.ready <= 1'b0;
                end else begin
                    chr_if.ready <= 1'b1;
                end
            end
        end
    end

    // gap before the next request; valid is only lowered when a gap follows
    task automatic hold_off();
        int gap;
        int r;
        if (src_calm_left > 0) begin
            src_calm_left--;
            gap = 0;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 4) begin
                src_calm_left = $urandom_range(10, 30);
                gap = 0;
            end else if (r < 50) begin
                gap = 0;
            end else if (r < 93) begin
                gap = $urandom_range(1, 4);
            end else begin
                gap = $urandom_range(20, 70);
            end
        end
        if (gap > 0) begin
            req_if.valid  <= 1'b0;
            req_if.value  <= $urandom;
            req_if.opcode <= t_opcode'($urandom_range(0, 3));
            repeat (gap) @(posedge clk);
        end
    endtask

    // present one request and hold it until taken
    task automatic send_request(input t_request req);
        pending_q.push_back(req);
        req_if.valid  <= 1'b1;
        req_if.value  <= req.value;
        req_if.opcode <= req.opcode;
        do @(posedge clk); while (req_if.ready !== 1'b1);
    endtask

    // stop sending until every expected character has arrived
    task automatic drain_expected();
        req_if.valid <= 1'b0;
        do @(posedge clk); while (expected_chars_q.size() != 0);
    endtask

    function automatic t_opcode pick_opcode();
        int r;
        r = $urandom_range(0, 19);
        if (r < 6) begin
            return OP_SDEC;
        end else if (r < 12) begin
            return OP_UDEC;
        end else if (r < 19) begin
            return OP_HEX;
        end
        return OP_RSVD;
    endfunction

    // full-range words mixed with digit-count boundaries and small values
    function automatic t_value pick_value();
        t_value p;
        int     r;
        r = $urandom_range(0, 9);
        case (r)
            4: begin
                return t_value'($urandom_range(0, 20));
            end
            5: begin
                return 32'd0 - t_value'($urandom_range(1, 20));
            end
            6: begin
                p = 32'd1;
                repeat ($urandom_range(0, 9)) p = p * 32'd10;
                return p + t_value'($urandom_range(0, 2)) - 32'd1;
            end
            7: begin
                p = 32'd1 << (4 * $urandom_range(0, 7));
                return p + t_value'($urandom_range(0, 2)) - 32'd1;
            end
            8: begin
                case ($urandom_range(0, 3))
                    0: return 32'h0000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h8000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            9: begin
                return t_value'($urandom) >> $urandom_range(0, 31);
            end
            default: begin
                return t_value'($urandom);
            end
        endcase
    endfunction

    // request source and end of run
    initial begin
        t_request req;
        int       sent;
        rst_n         = 1'b0;
        req_if.valid  = 1'b0;
        req_if.value  = '0;
        req_if.opcode = OP_SDEC;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            hold_off();
            send_request(directed_rows[i]);
        end
        drain_expected();

        // ignored opcode does not count towards the random total
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            req.opcode = pick_opcode();
            req.value  = pick_value();
            req.typed  = 1'b0;
            req.text   = "";
            hold_off();
            send_request(req);
            if (req.opcode != OP_RSVD) begin
                sent++;
                if (sent % DRAIN_EVERY == 0) begin
                    drain_expected();
                end
            end
        end

        drain_expected();
        // room for stray characters after the last expected one
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* int_to_ascii_formatter_unit.f */
+incdir+src
src/itoaf_pkg.sv
src/itoaf_if.sv
src/int_to_ascii_formatter_unit.sv
verif/int_to_ascii_formatter_unit_tb.sv
